// ===== src/tcdc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcdc_pkg
// Types and constants shared by the tetrahedron class deduplicating counter
// and its checker, and the corner sort used by the counter.
// ----------------------------------------------------------------------------
package tcdc_pkg;

    localparam int MAX_CLASSES = 4096;
    localparam int POINT_BITS  = 16;
    localparam int CORNERS     = 4;

    localparam int CORNER_W = 16;
    localparam int KEY_W    = CORNERS * CORNER_W;
    localparam int TINDEX_W = 20;
    localparam int WEIGHT_W = 21;
    localparam int IDX_W    = $clog2(MAX_CLASSES);
    localparam int COUNT_W  = IDX_W + 1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = WEIGHT_W'(1048576);
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = COUNT_W'(MAX_CLASSES);
    localparam logic [CORNER_W-1:0] POINT_MASK = CORNER_W'((32'd1 << POINT_BITS) - 32'd1);

    typedef struct packed {
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        logic [CORNER_W-1:0] corner_d;
        logic [TINDEX_W-1:0] tetra_index;
        logic                last_tetra;
    } in_word_t;

    typedef struct packed {
        logic [TINDEX_W-1:0] class_index;
        logic                is_new;
        logic [WEIGHT_W-1:0] class_weight;
        logic [12:0]         class_count;
        logic                table_full;
        logic                set_done;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPEND,
        ST_OUT
    } state_t;

    // Sorting network for four corners, smallest corner in the low bits.
    function automatic logic [KEY_W-1:0] make_key(input in_word_t w);
        logic [CORNER_W-1:0] c [CORNERS];
        logic [CORNER_W-1:0] t;
        c[0] = w.corner_a & POINT_MASK;
        c[1] = w.corner_b & POINT_MASK;
        c[2] = w.corner_c & POINT_MASK;
        c[3] = w.corner_d & POINT_MASK;
        if (c[0] > c[1]) begin t = c[0]; c[0] = c[1]; c[1] = t; end
        if (c[2] > c[3]) begin t = c[2]; c[2] = c[3]; c[3] = t; end
        if (c[0] > c[2]) begin t = c[0]; c[0] = c[2]; c[2] = t; end
        if (c[1] > c[3]) begin t = c[1]; c[1] = c[3]; c[3] = t; end
        if (c[1] > c[2]) begin t = c[1]; c[1] = c[2]; c[2] = t; end
        return {c[3], c[2], c[1], c[0]};
    endfunction

endpackage

// ===== src/tetrahedron_class_dedup_counter_core.sv =====
// ----------------------------------------------------------------------------
// tetrahedron_class_dedup_counter_core
// With reduction on, sorts four corners into a canonical key, searches the
// class table one entry a cycle and bumps a weight or appends a new class.
// ----------------------------------------------------------------------------
// With reduction off a word goes straight to the output stage; with an empty
// table it goes straight to append; else the search reads one stored key per
// cycle from slot 0 until a match or the last stored class, then appends.
// The next word is taken while the result waits in the output register, but
// not before the result has moved there.
// Reset: synchronous, active low; clears the class count, sets reduce_reg
// to 1; the table memories are not cleared and need no clearing pass.
module tetrahedron_class_dedup_counter_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcdc_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tcdc_pkg::out_word_t m_data
);
    import tcdc_pkg::*;

    logic [KEY_W-1:0]    key_mem    [MAX_CLASSES];
    logic [WEIGHT_W-1:0] weight_mem [MAX_CLASSES];

    state_t              state_reg, state_next;
    logic                reduce_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic                last_reg, last_next;
    out_word_t           res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    out_word_t           m_data_reg, m_data_next;

    logic [KEY_W-1:0]    rd_key;
    logic [WEIGHT_W-1:0] rd_weight;
    logic [WEIGHT_W-1:0] bumped;
    logic [COUNT_W-1:0]  addr_inc;
    logic                key_we, weight_we;
    logic [IDX_W-1:0]    wr_addr;
    logic [WEIGHT_W-1:0] wr_weight;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign addr_inc = {1'b0, addr_reg} + COUNT_W'(1);
    assign bumped   = (rd_weight < WEIGHT_MAX) ? rd_weight + WEIGHT_W'(1) : rd_weight;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        addr_next    = addr_reg;
        key_next     = key_reg;
        last_next    = last_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        key_we       = 1'b0;
        weight_we    = 1'b0;
        wr_addr      = addr_reg;
        wr_weight    = bumped;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                addr_next = '0;
                if (s_valid) begin
                    key_next    = make_key(s_data);
                    last_next   = s_data.last_tetra;
                    if (!reduce_reg) begin
                        res_next.class_index  = s_data.tetra_index;
                        res_next.is_new       = 1'b1;
                        res_next.class_weight = WEIGHT_W'(1);
                        res_next.class_count  = count_reg;
                        res_next.table_full   = 1'b0;
                        res_next.set_done     = s_data.last_tetra;
                        state_next            = ST_OUT;
                    end else if (count_reg == '0) begin
                        state_next = ST_APPEND;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                // read data belongs to addr_reg; the next address is issued now
                addr_next = addr_inc[IDX_W-1:0];
                if (rd_key == key_reg) begin
                    weight_we             = 1'b1;
                    res_next.class_index  = TINDEX_W'(addr_reg);
                    res_next.is_new       = 1'b0;
                    res_next.class_weight = bumped;
                    res_next.class_count  = count_reg;
                    res_next.table_full   = 1'b0;
                    res_next.set_done     = last_reg;
                    state_next            = ST_OUT;
                end else if (addr_inc == count_reg) begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND: begin
                res_next.set_done = last_reg;
                if (count_reg < COUNT_MAX) begin
                    key_we                = 1'b1;
                    weight_we             = 1'b1;
                    wr_addr               = count_reg[IDX_W-1:0];
                    wr_weight             = WEIGHT_W'(1);
                    count_next            = count_reg + COUNT_W'(1);
                    res_next.class_index  = TINDEX_W'(count_reg);
                    res_next.is_new       = 1'b1;
                    res_next.class_weight = WEIGHT_W'(1);
                    res_next.class_count  = count_reg + COUNT_W'(1);
                    res_next.table_full   = 1'b0;
                end else begin
                    res_next.class_index  = '0;
                    res_next.is_new       = 1'b0;
                    res_next.class_weight = '0;
                    res_next.class_count  = count_reg;
                    res_next.table_full   = 1'b1;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            reduce_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                reduce_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        key_reg    <= key_next;
        last_reg   <= last_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // Class table: one read and one write port per memory
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_addr] <= key_reg;
        end
        rd_key <= key_mem[addr_next];
    end

    always_ff @(posedge aclk) begin
        if (weight_we) begin
            weight_mem[wr_addr] <= wr_weight;
        end
        rd_weight <= weight_mem[addr_next];
    end

endmodule

// ===== src/tcdc_checker.sv =====
// ----------------------------------------------------------------------------
// tcdc_checker
// Port-level checks on the result words of the class deduplicating counter.
// ----------------------------------------------------------------------------
module tcdc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input tcdc_pkg::in_word_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input tcdc_pkg::out_word_t m_data
);
    import tcdc_pkg::*;

    // a waiting input word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while waiting");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // a freshly stored class starts at weight one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_new |-> m_data.class_weight == WEIGHT_W'(1)
                                     && !m_data.table_full)
        else $error("new class without unit weight");

    // an overflow reports no new class, zero weight and a full class count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.table_full |-> !m_data.is_new
            && m_data.class_weight == '0 && m_data.class_count == COUNT_MAX)
        else $error("overflow word malformed");

    // class count never passes the table size
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.class_count <= COUNT_MAX)
        else $error("class count beyond table size");

endmodule

bind tetrahedron_class_dedup_counter_core tcdc_checker u_tcdc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

// ===== sim/tetrahedron_class_dedup_counter_core_test.sv =====
// ----------------------------------------------------------------------------
// tetrahedron_class_dedup_counter_core_test
// Self-checking bench for the tetrahedron class deduplicating counter. It
// starts with directed corner orderings, then sends random tetrahedra, many
// reshuffled from earlier corner sets, with reduction switched between phases.
// Both sides idle at random, and the output is held off once for a long
// stretch.
// ----------------------------------------------------------------------------
module tetrahedron_class_dedup_counter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcdc_pkg::*;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_word_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_word_t m_data;

    tetrahedron_class_dedup_counter_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Class table as predicted: canonical key to slot, weight per slot.
    bit                  reduce_on = 1'b1;
    int                  slot_of_key [logic [KEY_W-1:0]];
    logic [WEIGHT_W-1:0] slot_weight [MAX_CLASSES];
    int                  stored_count = 0;

    in_word_t  tetra_backlog [$];
    out_word_t class_results_due [$];
    in_word_t  corner_sets [$];

    int words_pushed   = 0;
    int words_in       = 0;
    int words_in_seen  = 0;
    int words_out      = 0;
    int words_out_seen = 0;
    int mismatches     = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    int hold_off_req   = 0;
    int hold_off_ack   = 0;
    bit idle_on        = 1'b1;
    bit on_bus         = 1'b0;

    function automatic logic [KEY_W-1:0] canon_key(in_word_t w);
        logic [CORNER_W-1:0] c [4];
        logic [CORNER_W-1:0] t;
        logic [CORNER_W-1:0] mask;
        mask = CORNER_W'((1 << POINT_BITS) - 1);
        c[0] = w.corner_a & mask;
        c[1] = w.corner_b & mask;
        c[2] = w.corner_c & mask;
        c[3] = w.corner_d & mask;
        for (int i = 1; i < 4; i++)
            for (int j = i; j > 0 && c[j-1] > c[j]; j--) begin
                t      = c[j];
                c[j]   = c[j-1];
                c[j-1] = t;
            end
        return {c[3], c[2], c[1], c[0]};
    endfunction

    function automatic out_word_t classify_tetra(in_word_t w);
        out_word_t        r;
        logic [KEY_W-1:0] key;
        int               slot;
        r = '0;
        r.set_done = w.last_tetra;
        if (!reduce_on) begin
            r.class_index  = w.tetra_index;
            r.is_new       = 1'b1;
            r.class_weight = WEIGHT_W'(1);
        end else begin
            key = canon_key(w);
            if (slot_of_key.exists(key)) begin
                slot = slot_of_key[key];
                if (slot_weight[slot] < WEIGHT_MAX)
                    slot_weight[slot]++;
                r.class_index  = TINDEX_W'(slot);
                r.class_weight = slot_weight[slot];
            end else if (stored_count < MAX_CLASSES) begin
                slot_of_key[key]          = stored_count;
                slot_weight[stored_count] = WEIGHT_W'(1);
                r.class_index  = TINDEX_W'(stored_count);
                r.is_new       = 1'b1;
                r.class_weight = WEIGHT_W'(1);
                stored_count++;
            end else begin
                r.table_full = 1'b1;
            end
        end
        r.class_count = COUNT_W'(stored_count);
        return r;
    endfunction

    function automatic in_word_t tetra(int a, int b, int c, int d, int idx, bit last);
        in_word_t w;
        w.corner_a    = CORNER_W'(a);
        w.corner_b    = CORNER_W'(b);
        w.corner_c    = CORNER_W'(c);
        w.corner_d    = CORNER_W'(d);
        w.tetra_index = TINDEX_W'(idx);
        w.last_tetra  = last;
        return w;
    endfunction

    // Mostly reshuffle an earlier corner set so classes repeat; otherwise
    // draw fresh corners, some from a tiny range so that equal corners are likely.
    function automatic in_word_t random_tetra();
        in_word_t            w;
        logic [CORNER_W-1:0] c [4];
        logic [CORNER_W-1:0] t;
        int                  j;
        if (corner_sets.size() != 0 && $urandom_range(0, 99) < 55) begin
            w = corner_sets[$urandom_range(0, corner_sets.size() - 1)];
            c = '{w.corner_a, w.corner_b, w.corner_c, w.corner_d};
            for (int i = 3; i > 0; i--) begin
                j    = $urandom_range(0, i);
                t    = c[i];
                c[i] = c[j];
                c[j] = t;
            end
        end else begin
            for (int i = 0; i < 4; i++)
                c[i] = ($urandom_range(0, 99) < 35) ? CORNER_W'($urandom_range(0, 7))
                                                    : CORNER_W'($urandom());
        end
        w = tetra(int'(c[0]), int'(c[1]), int'(c[2]), int'(c[3]),
                  $urandom_range(0, (1 << TINDEX_W) - 1), $urandom_range(0, 15) == 0);
        corner_sets = {corner_sets, w};
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("%0t ns: result word %0d: %s", $time, words_out, msg);
    endtask

    task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
    endtask

    task automatic offer(in_word_t w);
        tetra_backlog = {tetra_backlog, w};
        words_pushed++;
    endtask

    task automatic wait_idle();
        while (words_in != words_pushed || class_results_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_reduce(bit on);
        wait_idle();
        repeat (8) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    always @(negedge aclk) begin
        if (words_in != words_in_seen) begin
            words_in_seen = words_in;
            on_bus        = 1'b0;
            gap_left      = idle_on ? pick_gap() : 0;
        end
        if (!on_bus) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (tetra_backlog.size() != 0) begin
                s_data <= tetra_backlog.pop_front();
                on_bus = 1'b1;
            end
        end
        s_valid <= on_bus;
    end

    always @(negedge aclk) begin
        if (hold_off_ack != hold_off_req) begin
            hold_off_ack = hold_off_req;
            hold_left    = 300;
        end
        if (words_out != words_out_seen) begin
            words_out_seen = words_out;
            stall_left     = idle_on ? pick_gap() : 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Take the result before the new word so a stray result never pairs up
    // with an expectation pushed at the same edge.
    always @(posedge aclk) begin : monitor
        out_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                words_out++;
                if (class_results_due.size() == 0) begin
                    report_mismatch("result word with nothing outstanding");
                end else begin
                    want = class_results_due.pop_front();
                    check_field("class_index", 32'(m_data.class_index),
                                32'(want.class_index));
                    check_field("is_new", 32'(m_data.is_new), 32'(want.is_new));
                    check_field("class_weight", 32'(m_data.class_weight),
                                32'(want.class_weight));
                    check_field("class_count", 32'(m_data.class_count),
                                32'(want.class_count));
                    check_field("table_full", 32'(m_data.table_full),
                                32'(want.table_full));
                    check_field("set_done", 32'(m_data.set_done), 32'(want.set_done));
                end
            end
            if (s_valid && s_ready) begin
                class_results_due = {class_results_due, classify_tetra(s_data)};
                words_in++;
            end
            if (cfg_we)
                reduce_on = cfg_wdata;
        end
    end

    initial begin
        #400ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reduction is on out of reset: orderings, repeated corners, extremes.
        offer(tetra(0, 0, 0, 0, 0, 0));
        offer(tetra('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFFF, 0));
        offer(tetra(4, 3, 2, 1, 7, 0));
        offer(tetra(1, 2, 3, 4, 8, 0));
        offer(tetra(3, 1, 4, 2, 'hFFFFF, 1));
        offer(tetra(5, 5, 9, 5, 10, 0));
        offer(tetra(9, 5, 5, 5, 11, 0));
        offer(tetra(5, 9, 9, 5, 12, 0));
        offer(tetra(0, 'hFFFF, 0, 'hFFFF, 13, 0));
        offer(tetra('hFFFF, 0, 'hFFFF, 0, 14, 1));
        offer(tetra(0, 0, 0, 0, 0, 0));
        offer(tetra('hAAAA, 'h5555, 'hFFFF, 0, 15, 0));
        offer(tetra(0, 'hFFFF, 'h5555, 'hAAAA, 16, 0));

        set_reduce(1'b0);
        offer(tetra(1, 2, 3, 4, 0, 0));
        offer(tetra('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFFF, 1));
        offer(tetra(0, 0, 0, 0, 'h12345, 0));
        offer(tetra(4, 3, 2, 1, 'h5555A, 0));

        // Hold the output back while the sender keeps offering words.
        set_reduce(1'b1);
        repeat (500) offer(random_tetra());
        hold_off_req++;

        set_reduce(1'b0);
        repeat (300) offer(random_tetra());

        set_reduce(1'b1);
        idle_on = 1'b0;
        repeat (450) offer(random_tetra());
        wait_idle();
        idle_on = 1'b1;
        repeat (450) offer(random_tetra());

        wait_idle();
        idle_on = 1'b0;
        repeat (16) offer(random_tetra());
        wait_idle();
        idle_on = 1'b1;

        set_reduce(1'b0);
        repeat (20) offer(random_tetra());
        set_reduce(1'b1);
        repeat (30) offer(random_tetra());

        wait_idle();
        repeat (MAX_CLASSES + 8) @(negedge aclk);
        if (mismatches == 0 && class_results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
